/* rtl/asrs_pkg.sv */
// Shared types and constants of the analog sensor range scaler.
package asrs_pkg;

    // Configuration port: 64-bit data, one register every 8 bytes
    localparam int DATA_W = 64;
    localparam int ADDR_W = 6;
    localparam int ADDR_LSB = 3;
    localparam int INDEX_W = ADDR_W - ADDR_LSB;

    localparam int TOL_W = 8;
    localparam int PERCENT_DIV = 100;

    typedef enum logic [INDEX_W-1:0] {
        REG_MIN_MV,
        REG_MAX_MV,
        REG_VALUE_LO,
        REG_VALUE_HI,
        REG_TOLERANCE
    } reg_index_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic check;
        logic mul_step;
        logic round;
        logic div_step;
        logic apply;
        logic publish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic ok;
    } sts_t;

endpackage

/* rtl/analog_sensor_range_scaler.sv */
// Top level of the analog sensor range scaler.
// Maps one millivolt sample at a time onto the value range set by the two value registers
// (millionths) after checking it against the nominal span widened by the tolerance band; an
// out-of-band sample returns the held value with status 1. One transaction is in work at a time.
// An in-band sample passes through the one-bit-per-cycle shift-add multiplier and the
// one-bit-per-cycle restoring divider before its result is published; an out-of-band sample
// skips both and is published after the check.
// The result waits in an output register, so the next sample is accepted while it is stalled.
// Configuration registers sit at byte addresses 0, 8, 16, 24, 32 of the 64-bit register port.
module analog_sensor_range_scaler #(
    parameter int SAMPLE_BITS = 16,
    parameter int VALUE_BITS  = 48
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [asrs_pkg::ADDR_W-1:0]          paddr,
    input  logic [asrs_pkg::DATA_W-1:0]          pwdata,
    output logic [asrs_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [SAMPLE_BITS-1:0]               sample_mv,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [VALUE_BITS-1:0]         value_micro,
    output logic                                 status
);

    logic [SAMPLE_BITS-1:0]         min_mv;
    logic [SAMPLE_BITS-1:0]         max_mv;
    logic signed [VALUE_BITS-1:0]   value_lo;
    logic signed [VALUE_BITS-1:0]   value_hi;
    logic [asrs_pkg::TOL_W-1:0]     tolerance;
    asrs_pkg::cmd_t                 cmd;
    asrs_pkg::sts_t                 sts;

    asrs_regs #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .min_mv    (min_mv),
        .max_mv    (max_mv),
        .value_lo  (value_lo),
        .value_hi  (value_hi),
        .tolerance (tolerance)
    );

    asrs_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    asrs_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .sample_mv   (sample_mv),
        .min_mv      (min_mv),
        .max_mv      (max_mv),
        .value_lo    (value_lo),
        .value_hi    (value_hi),
        .tolerance   (tolerance),
        .value_micro (value_micro),
        .status      (status)
    );

endmodule

/* rtl/asrs_regs.sv */
// Configuration register file behind the APB-style port.
module asrs_regs #(
    parameter int SAMPLE_BITS = 16,
    parameter int VALUE_BITS  = 48
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [asrs_pkg::ADDR_W-1:0]          paddr,
    input  logic [asrs_pkg::DATA_W-1:0]          pwdata,
    output logic [asrs_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    output logic [SAMPLE_BITS-1:0]               min_mv,
    output logic [SAMPLE_BITS-1:0]               max_mv,
    output logic signed [VALUE_BITS-1:0]         value_lo,
    output logic signed [VALUE_BITS-1:0]         value_hi,
    output logic [asrs_pkg::TOL_W-1:0]           tolerance
);

    logic [SAMPLE_BITS-1:0]         min_mv_reg;
    logic [SAMPLE_BITS-1:0]         max_mv_reg;
    logic signed [VALUE_BITS-1:0]   value_lo_reg;
    logic signed [VALUE_BITS-1:0]   value_hi_reg;
    logic [asrs_pkg::TOL_W-1:0]     tolerance_reg;
    logic [asrs_pkg::INDEX_W-1:0]   index;
    logic                           wr_en;

    assign index  = paddr[asrs_pkg::ADDR_W-1:asrs_pkg::ADDR_LSB];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_mv_reg    <= '0;
            max_mv_reg    <= SAMPLE_BITS'(5000);
            value_lo_reg  <= '0;
            value_hi_reg  <= VALUE_BITS'(1000000);
            tolerance_reg <= '0;
        end
        else if (wr_en)
        begin
            case (asrs_pkg::reg_index_t'(index))
                asrs_pkg::REG_MIN_MV:    min_mv_reg    <= pwdata[SAMPLE_BITS-1:0];
                asrs_pkg::REG_MAX_MV:    max_mv_reg    <= pwdata[SAMPLE_BITS-1:0];
                asrs_pkg::REG_VALUE_LO:  value_lo_reg  <= pwdata[VALUE_BITS-1:0];
                asrs_pkg::REG_VALUE_HI:  value_hi_reg  <= pwdata[VALUE_BITS-1:0];
                asrs_pkg::REG_TOLERANCE: tolerance_reg <= pwdata[asrs_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (asrs_pkg::reg_index_t'(index))
            asrs_pkg::REG_MIN_MV:    prdata = asrs_pkg::DATA_W'(min_mv_reg);
            asrs_pkg::REG_MAX_MV:    prdata = asrs_pkg::DATA_W'(max_mv_reg);
            asrs_pkg::REG_VALUE_LO:  prdata = asrs_pkg::DATA_W'(value_lo_reg);
            asrs_pkg::REG_VALUE_HI:  prdata = asrs_pkg::DATA_W'(value_hi_reg);
            asrs_pkg::REG_TOLERANCE: prdata = asrs_pkg::DATA_W'(tolerance_reg);
            default:                 prdata = '0;
        endcase
    end

    assign min_mv    = min_mv_reg;
    assign max_mv    = max_mv_reg;
    assign value_lo  = value_lo_reg;
    assign value_hi  = value_hi_reg;
    assign tolerance = tolerance_reg;

endmodule

/* rtl/asrs_ctrl.sv */
// Sequencer of the scaler: steps the datapath through check, multiply and divide.
module asrs_ctrl #(
    parameter int SAMPLE_BITS = 16,
    parameter int VALUE_BITS  = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  asrs_pkg::sts_t    sts,
    output asrs_pkg::cmd_t    cmd
);

    localparam int PROD_W = SAMPLE_BITS + VALUE_BITS;
    localparam int CNT_W  = $clog2(PROD_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_ROUND,
        S_DIV,
        S_APPLY,
        S_PUBLISH
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                cnt_next   = CNT_W'(SAMPLE_BITS - 1);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                // out of band: skip the arithmetic, keep the held value
                if (!sts.ok)
                begin
                    state_next = S_PUBLISH;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                    cnt_next     = cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_next = S_ROUND;
                    end
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                cnt_next   = CNT_W'(PROD_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = S_PUBLISH;
            end
            S_PUBLISH:
            begin
                if (slot_free)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_CHECK))
        else $error("accepted transaction did not start the check");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || !out_stall))
        else $error("result published over a pending transaction");

    a_valid_from_publish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_PUBLISH))
        else $error("out_valid raised outside publish");
`endif

endmodule

/* rtl/asrs_datapath.sv */
// Datapath of the scaler: band check, clamp, shift-add multiply, restoring divide.
module asrs_datapath #(
    parameter int SAMPLE_BITS = 16,
    parameter int VALUE_BITS  = 48
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  asrs_pkg::cmd_t                       cmd,
    output asrs_pkg::sts_t                       sts,
    input  logic [SAMPLE_BITS-1:0]               sample_mv,
    input  logic [SAMPLE_BITS-1:0]               min_mv,
    input  logic [SAMPLE_BITS-1:0]               max_mv,
    input  logic signed [VALUE_BITS-1:0]         value_lo,
    input  logic signed [VALUE_BITS-1:0]         value_hi,
    input  logic [asrs_pkg::TOL_W-1:0]           tolerance,
    output logic signed [VALUE_BITS-1:0]         value_micro,
    output logic                                 status
);

    localparam int PROD_W = SAMPLE_BITS + VALUE_BITS;
    localparam int EXT_W  = VALUE_BITS + 1;
    localparam int CMP_W  = SAMPLE_BITS + asrs_pkg::TOL_W;

    logic [SAMPLE_BITS-1:0]         mv_reg;
    logic [SAMPLE_BITS-1:0]         range_reg;
    logic [SAMPLE_BITS-1:0]         excess_reg;
    logic                           span_ok_reg;
    logic                           ok_reg;
    logic                           neg_reg;
    logic [VALUE_BITS-1:0]          mag_reg;
    logic [SAMPLE_BITS-1:0]         mul_b_reg;
    logic [PROD_W-1:0]              acc_reg;
    logic [SAMPLE_BITS-1:0]         rem_reg;
    logic [VALUE_BITS-1:0]          held_reg;
    logic [VALUE_BITS-1:0]          value_micro_reg;
    logic                           status_reg;

    logic [SAMPLE_BITS-1:0]         excess_next;
    logic [CMP_W-1:0]               over_scaled;
    logic [CMP_W-1:0]               band_scaled;
    logic [SAMPLE_BITS-1:0]         mv_clamped;
    logic [EXT_W-1:0]               lo_ext;
    logic [EXT_W-1:0]               hi_ext;
    logic                           neg_next;
    logic [EXT_W-1:0]               mag_full;
    logic [SAMPLE_BITS:0]           trial;
    logic [SAMPLE_BITS:0]           trial_sub;
    logic                           trial_ge;
    logic [EXT_W-1:0]               res_full;

    // distance of the sample outside min..max
    always_comb
    begin
        if (sample_mv < min_mv)
        begin
            excess_next = min_mv - sample_mv;
        end
        else if (sample_mv > max_mv)
        begin
            excess_next = sample_mv - max_mv;
        end
        else
        begin
            excess_next = '0;
        end
    end

    // excess <= floor(range*tol/100)  <=>  excess*100 <= range*tol
    assign over_scaled = CMP_W'(excess_reg) * CMP_W'(asrs_pkg::PERCENT_DIV);
    assign band_scaled = CMP_W'(range_reg) * CMP_W'(tolerance);

    always_comb
    begin
        if (mv_reg < min_mv)
        begin
            mv_clamped = min_mv;
        end
        else if (mv_reg > max_mv)
        begin
            mv_clamped = max_mv;
        end
        else
        begin
            mv_clamped = mv_reg;
        end
    end

    assign lo_ext   = {value_lo[VALUE_BITS-1], value_lo};
    assign hi_ext   = {value_hi[VALUE_BITS-1], value_hi};
    assign neg_next = ($signed(hi_ext) < $signed(lo_ext));
    assign mag_full = neg_next ? (lo_ext - hi_ext) : (hi_ext - lo_ext);

    assign trial     = {rem_reg, acc_reg[PROD_W-1]};
    assign trial_ge  = (trial >= {1'b0, range_reg});
    assign trial_sub = trial - {1'b0, range_reg};

    assign res_full = neg_reg ? (lo_ext - EXT_W'(acc_reg[VALUE_BITS-1:0]))
                              : (lo_ext + EXT_W'(acc_reg[VALUE_BITS-1:0]));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mv_reg      <= sample_mv;
            range_reg   <= max_mv - min_mv;
            excess_reg  <= excess_next;
            span_ok_reg <= (max_mv > min_mv);
        end
        if (cmd.check)
        begin
            mul_b_reg <= mv_clamped - min_mv;
            mag_reg   <= mag_full[VALUE_BITS-1:0];
            neg_reg   <= neg_next;
            acc_reg   <= '0;
        end
        if (cmd.mul_step)
        begin
            acc_reg   <= {acc_reg[PROD_W-2:0], 1'b0}
                       + (mul_b_reg[SAMPLE_BITS-1] ? PROD_W'(mag_reg) : '0);
            mul_b_reg <= {mul_b_reg[SAMPLE_BITS-2:0], 1'b0};
        end
        if (cmd.round)
        begin
            // add half the range so the floor divide rounds to nearest
            acc_reg <= acc_reg + PROD_W'(range_reg >> 1);
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
            acc_reg <= {acc_reg[PROD_W-2:0], trial_ge};
        end
        if (cmd.publish)
        begin
            value_micro_reg <= held_reg;
            status_reg      <= !ok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg   <= 1'b0;
            held_reg <= '0;
        end
        else
        begin
            if (cmd.check)
            begin
                ok_reg <= span_ok_reg && (over_scaled <= band_scaled);
            end
            if (cmd.apply)
            begin
                held_reg <= res_full[VALUE_BITS-1:0];
            end
        end
    end

    assign sts.ok      = ok_reg;
    assign value_micro = value_micro_reg;
    assign status      = status_reg;

`ifndef ASSERT_OFF
    a_rem_below_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> (rem_reg < range_reg))
        else $error("division remainder reached the range");
`endif

endmodule

/* dv/analog_sensor_range_scaler_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the analog sensor range scaler: random samples under random settings.

typedef struct packed {
    logic [47:0] value;
    logic        status;
} reading_t;

class scaler_scoreboard;
    logic [15:0] min_mv;
    logic [15:0] max_mv;
    logic [47:0] value_lo;
    logic [47:0] value_hi;
    logic [7:0]  tolerance;
    logic [47:0] held_value;
    reading_t    expected_readings[$];
    int          mismatches;
    int          samples;
    int          faults;

    function new();
        min_mv     = 16'd0;
        max_mv     = 16'd5000;
        value_lo   = 48'd0;
        value_hi   = 48'd1000000;
        tolerance  = 8'd0;
        held_value = 48'd0;
        mismatches = 0;
        samples    = 0;
        faults     = 0;
    endfunction

    // Upper bits beyond each register's width drop out here
    function void set_reg(int idx, logic [63:0] data);
        case (idx)
            asrs_pkg::REG_MIN_MV:    min_mv = data[15:0];
            asrs_pkg::REG_MAX_MV:    max_mv = data[15:0];
            asrs_pkg::REG_VALUE_LO:  value_lo = data[47:0];
            asrs_pkg::REG_VALUE_HI:  value_hi = data[47:0];
            asrs_pkg::REG_TOLERANCE: tolerance = data[7:0];
            default: ;
        endcase
    endfunction

    function int unsigned band_mv();
        int unsigned span;
        if (max_mv <= min_mv)
            return 0;
        span = max_mv - min_mv;
        return span * tolerance / asrs_pkg::PERCENT_DIV;
    endfunction

    function int unsigned window_lo();
        int unsigned band;
        band = band_mv();
        return (band >= min_mv) ? 0 : min_mv - band;
    endfunction

    function int unsigned window_hi();
        int unsigned top;
        top = max_mv + band_mv();
        return (top > 65535) ? 65535 : top;
    endfunction

    function void note_sample(logic [15:0] sample);
        int unsigned      span;
        int unsigned      band;
        int unsigned      mv;
        int unsigned      offset;
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic [63:0]      mag;
        logic [63:0]      step;
        logic [127:0]     scaled;
        logic             falling;
        logic             fault;
        fault = 1'b1;
        if (max_mv > min_mv)
        begin
            span = max_mv - min_mv;
            band = band_mv();
            mv = sample;
            if (mv + band >= min_mv && mv <= max_mv + band)
            begin
                if (mv < min_mv)
                    mv = min_mv;
                if (mv > max_mv)
                    mv = max_mv;
                offset = mv - min_mv;
                lo = {{16{value_lo[47]}}, value_lo};
                hi = {{16{value_hi[47]}}, value_hi};
                falling = hi < lo;
                mag = falling ? 64'(lo - hi) : 64'(hi - lo);
                // round the magnitude half up, so a falling map rounds away from zero too
                scaled = 128'(mag) * 128'(offset) + 128'(span / 2);
                step = 64'(scaled / 128'(span));
                held_value = falling ? 48'(lo - step) : 48'(lo + step);
                fault = 1'b0;
            end
        end
        samples++;
        if (fault)
            faults++;
        expected_readings.push_back('{held_value, fault});
    endfunction

    function void check_reading(logic [47:0] value, logic status);
        reading_t want;
        if (expected_readings.size() == 0)
        begin
            $error("unexpected transaction: value_micro %0d status %0d", $signed(value), status);
            mismatches++;
            return;
        end
        want = expected_readings.pop_front();
        if (value !== want.value)
        begin
            $error("value_micro: expected %0d, got %0d", $signed(want.value), $signed(value));
            mismatches++;
        end
        if (status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_readings.size();
    endfunction
endclass

module testbench;

    localparam int SAMPLE_BITS      = 16;
    localparam int VALUE_BITS       = 48;
    localparam int HALF_PERIOD      = 2;
    localparam int GAP_MAX          = 18;
    localparam int IDLE_LIMIT       = 2000;
    localparam int DRAIN_CYCLES     = 120;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_ITEMS      = 100;
    localparam int FIRST_UNUSED_REG = asrs_pkg::REG_TOLERANCE + 1;
    localparam int LAST_UNUSED_REG  = (1 << asrs_pkg::INDEX_W) - 1;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [asrs_pkg::ADDR_W-1:0]       paddr = '0;
    logic [asrs_pkg::DATA_W-1:0]       pwdata = '0;
    logic [asrs_pkg::DATA_W-1:0]       prdata;
    logic                              pready;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [SAMPLE_BITS-1:0]            sample_mv = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic signed [VALUE_BITS-1:0]      value_micro;
    logic                              status;

    scaler_scoreboard sb;
    bit               in_calm = 1'b0;
    bit               out_calm = 1'b0;
    int               reg_writes = 0;
    int               idle_cycles = 0;

    analog_sensor_range_scaler #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_top (.*);

    always #HALF_PERIOD clk = ~clk;

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    task automatic write_reg(input int idx, input logic [63:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= asrs_pkg::ADDR_W'(idx << asrs_pkg::ADDR_LSB);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, data);
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic [15:0] mv);
        int gap;
        gap = draw_gap(in_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_mv <= mv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_sample(mv);
    endtask

    // Hold off until every outstanding transaction has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] word;
        word = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: word[47:0] = 48'h7FFF_FFFF_FFFF;
            1: word[47:0] = 48'h8000_0000_0000;
            2: word[47:0] = 48'(int'($urandom_range(0, 2000)) - 1000);
            default: ;
        endcase
        return word;
    endfunction

    task automatic random_setting();
        int unsigned lo_mv;
        int unsigned hi_mv;
        int unsigned span;
        int          kind;
        logic [63:0] word;
        kind = $urandom_range(0, 9);
        lo_mv = $urandom_range(0, 65534);
        if (kind == 0)
        begin
            hi_mv = $urandom_range(0, lo_mv);
        end
        else if (kind == 9)
        begin
            lo_mv = 0;
            hi_mv = 65535;
        end
        else
        begin
            // narrow spans make exact halves in the rounding common
            span = (kind <= 4) ? $urandom_range(1, 16) : $urandom_range(1, 65535);
            hi_mv = (lo_mv + span > 65535) ? 65535 : lo_mv + span;
        end
        word = {$urandom, $urandom};
        word[15:0] = lo_mv[15:0];
        write_reg(asrs_pkg::REG_MIN_MV, word);
        word = {$urandom, $urandom};
        word[15:0] = hi_mv[15:0];
        write_reg(asrs_pkg::REG_MAX_MV, word);
        write_reg(asrs_pkg::REG_VALUE_LO, pick_value());
        write_reg(asrs_pkg::REG_VALUE_HI, pick_value());
        word = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: word[7:0] = 8'd0;
            1: word[7:0] = 8'hFF;
            default: ;
        endcase
        write_reg(asrs_pkg::REG_TOLERANCE, word);
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG), {$urandom, $urandom});
    endtask

    function automatic logic [15:0] pick_sample();
        int unsigned lo;
        int unsigned hi;
        int unsigned bounds[6];
        lo = sb.window_lo();
        hi = sb.window_hi();
        case ($urandom_range(0, 9))
            0, 1: return 16'($urandom);
            2:
            begin
                bounds[0] = (lo == 0) ? 0 : lo - 1;
                bounds[1] = lo;
                bounds[2] = hi;
                bounds[3] = (hi >= 65535) ? 65535 : hi + 1;
                bounds[4] = sb.min_mv;
                bounds[5] = sb.max_mv;
                return 16'(bounds[$urandom_range(0, 5)]);
            end
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_reading(value_micro, status);
    end

    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = draw_gap(out_calm);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int phase;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: fault before any good sample returns the cleared held value
        send_sample(16'd6000);
        send_sample(16'd0);
        send_sample(16'd5000);
        send_sample(16'd2500);
        send_sample(16'd5001);
        send_sample(16'hFFFF);
        drain();

        // Falling map over a two-millivolt span: exact halves, band edges on both sides
        write_reg(asrs_pkg::REG_MIN_MV, 64'd1000);
        write_reg(asrs_pkg::REG_MAX_MV, 64'd1002);
        write_reg(asrs_pkg::REG_VALUE_LO, 64'd3);
        write_reg(asrs_pkg::REG_VALUE_HI, -64'sd4);
        write_reg(asrs_pkg::REG_TOLERANCE, 64'd100);
        send_sample(16'd1001);
        send_sample(16'd997);
        send_sample(16'd998);
        send_sample(16'd1004);
        send_sample(16'd1005);
        drain();

        // Widest span, widest band, value ends at both extremes
        write_reg(asrs_pkg::REG_MIN_MV, 64'd0);
        write_reg(asrs_pkg::REG_MAX_MV, 64'd65535);
        write_reg(asrs_pkg::REG_VALUE_LO, 64'h0000_7FFF_FFFF_FFFF);
        write_reg(asrs_pkg::REG_VALUE_HI, 64'hFFFF_8000_0000_0000);
        write_reg(asrs_pkg::REG_TOLERANCE, 64'd255);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        send_sample(16'd32768);
        send_sample(16'd1);
        drain();

        // Empty span, then reversed span: every sample faults
        write_reg(asrs_pkg::REG_MIN_MV, 64'd100);
        write_reg(asrs_pkg::REG_MAX_MV, 64'd100);
        send_sample(16'd100);
        send_sample(16'd0);
        drain();
        write_reg(asrs_pkg::REG_MIN_MV, 64'd200);
        send_sample(16'd150);
        drain();

        // Junk above register widths and writes to unused addresses
        write_reg(FIRST_UNUSED_REG, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(LAST_UNUSED_REG, 64'h0123_4567_89AB_CDEF);
        write_reg(asrs_pkg::REG_MIN_MV, 64'hDEAD_BEEF_0000_000A);
        write_reg(asrs_pkg::REG_MAX_MV, 64'hFFFF_FFFF_FFFF_0014);
        write_reg(asrs_pkg::REG_VALUE_LO, 64'hA5A5_0000_0000_1000);
        write_reg(asrs_pkg::REG_VALUE_HI, 64'h5A5A_FFFF_FFFF_F000);
        write_reg(asrs_pkg::REG_TOLERANCE, 64'h0000_0000_0000_1234);
        send_sample(16'd0);
        send_sample(16'd25);
        send_sample(16'd15);
        drain();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            random_setting();
            repeat (PHASE_ITEMS) send_sample(pick_sample());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d samples, %0d of them out of band, with %0d register writes.",
                 sb.samples, sb.faults, reg_writes);
        $display("Spans, value ends and tolerances spanned extremes, empty and reversed cases.");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
